### hw/rtl/rbsf_pkg.sv
// Shared types and constants of the RGB 3x3 blur and sharpen filter.
package rbsf_pkg;

  localparam int MAX_SIZE_DEF = 1024;
  localparam int SIZE_MIN     = 3;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 3;
  localparam int TAG_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd3;

  // Register values after reset.
  localparam int RST_IMAGE_SIZE = 3;
  localparam logic [3:0] RST_DIVISOR = 4'd9;

  // Arithmetic constants.
  localparam logic [3:0] DIV7 = 4'd7;
  localparam logic [3:0] DIV9 = 4'd9;
  localparam int SHARP_GAIN   = 10;
  localparam int PIX_MAX      = 255;
  localparam int SUM_W        = 12;  // nine channel values
  localparam int INT_W        = 10;  // r+g+b of one pixel
  localparam int V_W          = 13;  // signed filter sum
  localparam int MAG_W        = 12;  // magnitude of the signed sum
  localparam int RECIP_W      = 13;
  localparam int PROD_W       = MAG_W + RECIP_W;
  localparam int RECIP_SHIFT  = 15;
  // Rounded-up reciprocals, exact for magnitudes below 2^15 / 6.
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd3641;
  localparam logic [RECIP_W-1:0] RECIP7 = 13'd4682;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;  // [0] red, [1] green, [2] blue

  // Sideband that follows a pixel through the pipeline.
  typedef struct packed {
    pix_t             px;
    logic [TAG_W-1:0] row;
    logic [TAG_W-1:0] col;
    logic             has_filt;
    logic             has_pass;
  } sb_t;

endpackage

### hw/rtl/rbsf_col_cell.sv
// One column of the 3x3 window, loaded from its right-hand neighbour on each shift.
module rbsf_col_cell (
  input  logic                   clk,
  input  logic                   shift,
  input  rbsf_pkg::pix_t [2:0]   load_col,
  output rbsf_pkg::pix_t [2:0]   col
);
  import rbsf_pkg::*;

  // The column moves one place left whenever a new pixel enters the window.
  always_ff @(posedge clk) begin
    if (shift) begin
      col <= load_col;
    end
  end

endmodule

### hw/rtl/rbsf_kernel.sv
// Pipelined 3x3 kernel: sums, darkest and brightest search, division and clamp.
module rbsf_kernel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 kernel_mode,
  input  logic [3:0]           divisor,
  input  logic                 filter_enable,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbsf_pkg::pix_t [8:0] win,
  input  rbsf_pkg::sb_t        in_sb,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbsf_pkg::sb_t        out_sb,
  output rbsf_pkg::pix_t       out_pix
);
  import rbsf_pkg::*;

  logic k1_v, k2_v, k3_v, k4_v;
  logic r1, r2, r3, r4;
  sb_t  k1_sb, k2_sb, k3_sb, k4_sb;

  // Stage one: channel sums and pixel intensities.
  pix_t [8:0]                    k1_win;
  logic [NUM_CHAN-1:0][SUM_W-1:0] k1_sum, sum_c;
  logic [8:0][INT_W-1:0]          k1_int, int_c;

  // Stage two: darkest and brightest pixels.
  logic [NUM_CHAN-1:0][SUM_W-1:0] k2_sum;
  pix_t                           k2_ctr, k2_min, k2_max;
  logic [3:0]                     min_k, max_k;
  logic [INT_W-1:0]               min_i, max_i;

  // Stage three: signed sum per channel.
  logic [NUM_CHAN-1:0][V_W-1:0]   k3_acc, acc_c;

  // Stage four: magnitude and reciprocal product.
  logic [NUM_CHAN-1:0]            k4_neg;
  logic [NUM_CHAN-1:0][MAG_W-1:0] k4_mag;
  logic [NUM_CHAN-1:0][PROD_W-1:0] k4_prod;
  logic                           k4_div;
  logic [RECIP_W-1:0]             recip;

  assign r4       = !k4_v || out_ready;
  assign r3       = !k3_v || r4;
  assign r2       = !k2_v || r3;
  assign r1       = !k1_v || r2;
  assign in_ready = r1;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      int_c[k] = INT_W'(win[k][0]) + INT_W'(win[k][1]) + INT_W'(win[k][2]);
    end
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum_c[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sum_c[ch] = sum_c[ch] + SUM_W'(win[k][ch]);
      end
    end
  end

  // Row-by-row scan: the darkest takes the last of equals, the brightest the first.
  always_comb begin
    min_k = '0;
    max_k = '0;
    min_i = k1_int[0];
    max_i = k1_int[0];
    for (int k = 1; k < 9; k++) begin
      if (k1_int[k] <= min_i) begin
        min_i = k1_int[k];
        min_k = 4'(k);
      end
      if (k1_int[k] > max_i) begin
        max_i = k1_int[k];
        max_k = 4'(k);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc_c[ch] = V_W'(k2_sum[ch]);
      if (kernel_mode) begin
        acc_c[ch] = V_W'(k2_ctr[ch]) * V_W'(SHARP_GAIN) - acc_c[ch];
      end
      if (filter_enable) begin
        acc_c[ch] = acc_c[ch] - V_W'(k2_min[ch]) - V_W'(k2_max[ch]);
      end
    end
  end

  assign recip = (divisor == DIV9) ? RECIP9 : RECIP7;

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      k1_v <= 1'b0;
      k2_v <= 1'b0;
      k3_v <= 1'b0;
      k4_v <= 1'b0;
    end else begin
      if (r1) k1_v <= in_valid;
      if (r2) k2_v <= k1_v;
      if (r3) k3_v <= k2_v;
      if (r4) k4_v <= k3_v;
    end
  end

  // Payload of the four stages.
  always_ff @(posedge clk) begin
    if (r1) begin
      k1_sb  <= in_sb;
      k1_win <= win;
      k1_sum <= sum_c;
      k1_int <= int_c;
    end
    if (r2) begin
      k2_sb  <= k1_sb;
      k2_sum <= k1_sum;
      k2_ctr <= k1_win[4];
      k2_min <= k1_win[min_k];
      k2_max <= k1_win[max_k];
    end
    if (r3) begin
      k3_sb  <= k2_sb;
      k3_acc <= acc_c;
    end
    if (r4) begin
      k4_sb  <= k3_sb;
      k4_div <= (divisor == DIV9) || (divisor == DIV7);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        k4_neg[ch]  <= k3_acc[ch][V_W-1];
        k4_mag[ch]  <= k3_acc[ch][V_W-1] ? MAG_W'(-k3_acc[ch]) : MAG_W'(k3_acc[ch]);
        k4_prod[ch] <= PROD_W'(k3_acc[ch][V_W-1] ? MAG_W'(-k3_acc[ch]) : MAG_W'(k3_acc[ch]))
                       * PROD_W'(recip);
      end
    end
  end

  // Quotient, sign and the clamp of sharpen mode.
  always_comb begin
    logic [MAG_W-1:0] q;
    logic [V_W-1:0]   res;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      q   = k4_div ? MAG_W'(k4_prod[ch] >> RECIP_SHIFT) : k4_mag[ch];
      res = k4_neg[ch] ? V_W'(-{1'b0, q}) : V_W'({1'b0, q});
      if (kernel_mode) begin
        if (k4_neg[ch]) begin
          out_pix[ch] = '0;
        end else if (q > MAG_W'(PIX_MAX)) begin
          out_pix[ch] = CHAN_W'(PIX_MAX);
        end else begin
          out_pix[ch] = q[CHAN_W-1:0];
        end
      end else begin
        out_pix[ch] = res[CHAN_W-1:0];
      end
    end
  end

  assign out_valid = k4_v;
  assign out_sb    = k4_sb;

endmodule

### hw/rtl/rgb_3x3_blur_sharpen_filter.sv
// Top level of the RGB 3x3 blur and sharpen filter.
// Takes one raster pixel per clock while the result side keeps pace. The pixel's position
// sets which results it causes: border pixels come back unchanged, and each interior pixel
// comes back filtered when the pixel below and to its right arrives, so a pixel causes zero,
// one or two transactions on the result side. A pixel that causes two (the last column of
// rows from 2 on, and the last row from column 2 on) holds the result port for both, so input
// flows at one pixel per clock while results are taken at that pace, and is held back while
// such a pair is sent. A filtered result leaves after its pixel passes the line store read,
// the window shift, four kernel stages and the output register.
// The line store is one memory with one read and one write port each cycle; it needs
// no clearing pass. Writing image_size restarts the frame at row 0, column 0.
module rgb_3x3_blur_sharpen_filter #(
  parameter int MAX_SIZE = rbsf_pkg::MAX_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbsf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [9:0]                        out_row,
  output logic [9:0]                        out_col,
  output logic                              run_last
);
  import rbsf_pkg::*;

  localparam int CW = $clog2(MAX_SIZE);

  // Configuration registers; size_last is the effective size minus one.
  logic [CW-1:0] size_last;
  logic          kernel_mode;
  logic [3:0]    divisor;
  logic          filter_enable;

  logic [CW-1:0] row_cnt, col_cnt;
  logic          in_fire;
  logic          is_last_row;
  sb_t           in_sb;
  pix_t          in_px;

  // Line store: two rows back in the upper half, one row back in the lower.
  logic [2*NUM_CHAN*CHAN_W-1:0] line_mem [MAX_SIZE];
  logic [2*NUM_CHAN*CHAN_W-1:0] rd_data;
  pix_t          rd_top, rd_mid;

  logic          s1_v, s1_ready, s1_adv;
  sb_t           s1_sb;
  logic [CW-1:0] s1_col;

  logic          s2_v, s2_ready;
  sb_t           s2_sb;
  pix_t [2:0]    cell_col [3];
  pix_t [2:0]    new_col;
  pix_t [8:0]    win;

  logic          k_ready, k_valid, k_take;
  sb_t           k_sb;
  pix_t          k_pix;

  logic          p_v, p_filt, p_pass, p_ready, p_load, out_fire;
  pix_t          p_fpix, p_ppix, o_pix;
  logic [TAG_W-1:0] p_row, p_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_last     <= CW'(RST_IMAGE_SIZE - 1);
      kernel_mode   <= 1'b0;
      divisor       <= RST_DIVISOR;
      filter_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE: begin
          if (int'(cfg_data) < SIZE_MIN) begin
            size_last <= CW'(SIZE_MIN - 1);
          end else if (int'(cfg_data) > MAX_SIZE) begin
            size_last <= CW'(MAX_SIZE - 1);
          end else begin
            size_last <= CW'(cfg_data - CFG_DATA_W'(1));
          end
        end
        REG_KERNEL_MODE:   kernel_mode   <= cfg_data[0];
        REG_DIVISOR:       divisor       <= cfg_data[3:0];
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the incoming pixel by its position in the frame.
  assign in_ready    = s1_ready;
  assign in_fire     = in_valid && in_ready;
  assign in_px       = {in_blue, in_green, in_red};
  assign is_last_row = (row_cnt == size_last);

  always_comb begin
    in_sb.px       = in_px;
    in_sb.row      = TAG_W'(row_cnt);
    in_sb.col      = TAG_W'(col_cnt);
    in_sb.has_filt = (row_cnt >= CW'(2) || is_last_row) && (col_cnt >= CW'(2));
    in_sb.has_pass = (row_cnt == '0) || is_last_row || (col_cnt == '0)
                     || (col_cnt == size_last);
  end

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (cfg_valid && cfg_index == REG_IMAGE_SIZE) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_fire) begin
      if (col_cnt == size_last) begin
        col_cnt <= '0;
        row_cnt <= is_last_row ? '0 : row_cnt + CW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // Line store: read as the pixel is taken, written back as it enters the window.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= line_mem[col_cnt];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= {rd_mid, s1_sb.px};
    end
  end

  assign rd_top = rd_data[2*NUM_CHAN*CHAN_W-1:NUM_CHAN*CHAN_W];
  assign rd_mid = rd_data[NUM_CHAN*CHAN_W-1:0];

  assign s1_ready = !s1_v || s2_ready;
  assign s1_adv   = s1_v && s2_ready;
  assign s2_ready = !s2_v || k_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_ready) s1_v <= in_fire;
      if (s2_ready) s2_v <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sb  <= in_sb;
      s1_col <= col_cnt;
    end
    if (s1_adv) begin
      s2_sb <= s1_sb;
    end
  end

  // Window: three column cells, the newest column entering on the right.
  assign new_col = {s1_sb.px, rd_mid, rd_top};

  rbsf_col_cell u_cell2 (.clk(clk), .shift(s1_adv), .load_col(new_col),     .col(cell_col[2]));
  rbsf_col_cell u_cell1 (.clk(clk), .shift(s1_adv), .load_col(cell_col[2]), .col(cell_col[1]));
  rbsf_col_cell u_cell0 (.clk(clk), .shift(s1_adv), .load_col(cell_col[1]), .col(cell_col[0]));

  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      for (int k = 0; k < 3; k++) begin
        win[rr*3 + k] = cell_col[k][rr];
      end
    end
  end

  rbsf_kernel u_kernel (
    .clk           (clk),
    .rst           (rst),
    .kernel_mode   (kernel_mode),
    .divisor       (divisor),
    .filter_enable (filter_enable),
    .in_valid      (s2_v),
    .in_ready      (k_ready),
    .win           (win),
    .in_sb         (s2_sb),
    .out_valid     (k_valid),
    .out_ready     (k_take),
    .out_sb        (k_sb),
    .out_pix       (k_pix)
  );

  // Output register: holds a filtered result, a passthrough result or both, filtered first.
  assign run_last = !(p_filt && p_pass);
  assign out_fire = p_v && out_ready;
  assign p_ready  = !p_v || (out_ready && run_last);
  assign k_take   = p_ready || !(k_sb.has_filt || k_sb.has_pass);
  assign p_load   = k_valid && p_ready && (k_sb.has_filt || k_sb.has_pass);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v    <= 1'b0;
      p_filt <= 1'b0;
      p_pass <= 1'b0;
    end else if (p_load) begin
      p_v    <= 1'b1;
      p_filt <= k_sb.has_filt;
      p_pass <= k_sb.has_pass;
    end else if (out_fire) begin
      if (run_last) begin
        p_v <= 1'b0;
      end else begin
        p_filt <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_fpix <= k_pix;
      p_ppix <= k_sb.px;
      p_row  <= k_sb.row;
      p_col  <= k_sb.col;
    end
  end

  assign o_pix     = p_filt ? p_fpix : p_ppix;
  assign out_valid = p_v;
  assign out_red   = o_pix[0];
  assign out_green = o_pix[1];
  assign out_blue  = o_pix[2];
  assign out_row   = p_filt ? p_row - TAG_W'(1) : p_row;
  assign out_col   = p_filt ? p_col - TAG_W'(1) : p_col;

  // The first of two results is always followed by the second.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !run_last) |=> (out_valid && run_last))
    else $error("second result of a pixel missing");

  // The output register never holds an entry without a result.
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    p_v |-> (p_filt || p_pass))
    else $error("empty entry in output register");

  // Raster counters stay inside the frame.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (row_cnt <= size_last) && (col_cnt <= size_last))
    else $error("raster counter beyond image size");

endmodule

### bench/tb_rgb_3x3_blur_sharpen_filter.sv
// Self-checking testbench of the RGB 3x3 blur and sharpen filter.
`timescale 1ns / 100ps

module tb_rgb_3x3_blur_sharpen_filter;
  import rbsf_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LINE_DEPTH = 1024;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic run_last;

  // Shadow copy of the filter state and its registers.
  logic [23:0] line_two[LINE_DEPTH];
  logic [23:0] line_one[LINE_DEPTH];
  logic [23:0] win[9];
  int unsigned row_cnt;
  int unsigned col_cnt;
  logic [10:0] size_reg;
  logic sharpen_reg;
  logic [3:0] div_reg;
  logic drop_reg;

  pix_result_t pending_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  bit idle_on = 1'b1;

  rgb_3x3_blur_sharpen_filter uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_row(out_row), .out_col(out_col), .run_last(run_last)
  );

  // Clock generation.
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned side_len();
    if (size_reg < SIZE_MIN) return SIZE_MIN;
    if (size_reg > LINE_DEPTH) return LINE_DEPTH;
    return size_reg;
  endfunction

  function automatic int chan_of(logic [23:0] px, int k);
    return int'(px[8*k +: 8]);
  endfunction

  // Kernel applied to the current window.
  function automatic logic [23:0] kernel_pixel();
    int sum[3];
    int lo_val, hi_val, lo_k, hi_k, inten, v;
    logic [23:0] res;
    lo_val = 766;
    hi_val = -1;
    lo_k = 0;
    hi_k = 0;
    res = '0;
    for (int ch = 0; ch < 3; ch++) sum[ch] = 0;
    for (int k = 0; k < 9; k++) begin
      inten = 0;
      for (int ch = 0; ch < 3; ch++) begin
        sum[ch] += chan_of(win[k], ch);
        inten += chan_of(win[k], ch);
      end
      if (inten <= lo_val) begin
        lo_val = inten;
        lo_k = k;
      end
      if (inten > hi_val) begin
        hi_val = inten;
        hi_k = k;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      v = sum[ch];
      if (sharpen_reg) v = SHARP_GAIN * chan_of(win[4], ch) - v;
      if (drop_reg) v -= chan_of(win[lo_k], ch) + chan_of(win[hi_k], ch);
      if (div_reg == DIV9) v = v / 9;
      else if (div_reg == DIV7) v = v / 7;
      if (sharpen_reg) begin
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
      end
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic pix_result_t make_result(logic [23:0] px, int unsigned r, int unsigned c);
    pix_result_t e;
    e.red = px[7:0];
    e.green = px[15:8];
    e.blue = px[23:16];
    e.row = r[9:0];
    e.col = c[9:0];
    e.last = 1'b0;
    return e;
  endfunction

  // Advances the shadow state by one pixel and queues the results it causes.
  function automatic void predict_pixel(logic [23:0] px);
    pix_result_t res[$];
    int unsigned n, r, c;
    logic [23:0] top, mid;
    n = side_len();
    r = row_cnt;
    c = col_cnt;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    top = line_two[c];
    mid = line_one[c];
    for (int rr = 0; rr < 3; rr++) begin
      win[rr*3] = win[rr*3+1];
      win[rr*3+1] = win[rr*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    line_two[c] = mid;
    line_one[c] = px;
    if (r == 0) begin
      res.push_back(make_result(px, r, c));
    end else if (r < n - 1) begin
      if (c == 0) res.push_back(make_result(px, r, c));
      if (r >= 2 && c >= 2) res.push_back(make_result(kernel_pixel(), r - 1, c - 1));
      if (c == n - 1) res.push_back(make_result(px, r, c));
    end else begin
      if (c >= 2) res.push_back(make_result(kernel_pixel(), r - 1, c - 1));
      res.push_back(make_result(px, r, c));
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_q.push_back(res[i]);
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    row_cnt = r;
    col_cnt = c;
  endfunction

  // Result side back-pressure in random bursts.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    pix_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: row %0d col %0d rgb %0d %0d %0d", out_row, out_col,
                   out_red, out_green, out_blue);
      end else begin
        e = pending_q.pop_front();
        if (out_red !== e.red || out_green !== e.green || out_blue !== e.blue ||
            out_row !== e.row || out_col !== e.col || run_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected r%0d c%0d rgb %0d %0d %0d last %0d, ",
                      "got r%0d c%0d rgb %0d %0d %0d last %0d"},
                     e.row, e.col, e.red, e.green, e.blue, e.last,
                     out_row, out_col, out_red, out_green, out_blue, run_last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** rgb_3x3_blur_sharpen_filter: FAILED **");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= red;
    in_green <= green;
    in_blue <= blue;
    do @(posedge clk); while (!in_ready);
    predict_pixel({blue, green, red});
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, only once the filter has gone quiet.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_SIZE: begin
        size_reg = value;
        row_cnt = 0;
        col_cnt = 0;
      end
      REG_KERNEL_MODE: sharpen_reg = value[0];
      REG_DIVISOR: div_reg = value[3:0];
      REG_FILTER_ENABLE: drop_reg = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [10:0] size, logic sharpen, logic [3:0] div, logic drop);
    write_reg(REG_KERNEL_MODE, {10'd0, sharpen});
    write_reg(REG_DIVISOR, {7'd0, div});
    write_reg(REG_FILTER_ENABLE, {10'd0, drop});
    write_reg(REG_IMAGE_SIZE, size);
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] px;
    case ($urandom_range(0, 5))
      0: px = '0;
      1: px = '1;
      2: px = {3{8'($urandom_range(0, 255))}};
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  task automatic send_frame(int unsigned n, bit pause_midway);
    logic [23:0] px;
    for (int unsigned i = 0; i < n * n; i++) begin
      if (pause_midway && i == n * n / 2) wait_drained();
      px = rand_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16]);
    end
  endtask

  // Reset values: a 3x3 frame with blur and division by nine.
  task automatic test_reset_values();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd128, 8'd254);
    for (int i = 0; i < 6; i++) send_pixel(8'd255, 8'd0, 8'd127);
  endtask

  // Clamping of sharpen, blur wrap-around and ties in the intensity scan.
  task automatic test_kernel_corners();
    set_all(11'd3, 1'b1, 4'd1, 1'b0);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_pixel(8'd0, 8'd0, 8'd0);
      else send_pixel(8'd255, 8'd255, 8'd255);
    end
    set_all(11'd0, 1'b1, 4'd7, 1'b1);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_pixel(8'd255, 8'd255, 8'd255);
      else send_pixel(8'd10, 8'd10, 8'd10);
    end
    set_all(11'd2, 1'b0, 4'd0, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  // Sizes beyond the line store and the start of a frame at the largest size.
  task automatic test_large_size();
    logic [23:0] px;
    set_all(11'd2047, 1'b0, 4'd9, 1'b0);
    for (int i = 0; i < 5; i++) begin
      px = rand_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16]);
    end
    write_reg(REG_IMAGE_SIZE, 11'd1024);
    for (int i = 0; i < 24; i++) begin
      px = 24'($urandom);
      send_pixel(px[7:0], px[15:8], px[23:16]);
    end
    write_reg(REG_IMAGE_SIZE, 11'd1);
  endtask

  // Random settings with mostly whole frames and some cut-off ones.
  task automatic test_random_frames();
    int unsigned n;
    bit paused;
    logic [23:0] px;
    paused = 1'b0;
    while (pixels_sent < 260) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 7);
      set_all(11'(n), 1'($urandom), 4'($urandom_range(0, 15)), 1'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        for (int unsigned i = $urandom_range(1, n * n - 1); i > 0; i--) begin
          px = rand_pixel();
          send_pixel(px[7:0], px[15:8], px[23:16]);
        end
      end else begin
        send_frame(n, !paused);
        paused = 1'b1;
        if ($urandom_range(0, 2) == 0) send_frame(n, 1'b0);
      end
    end
  endtask

  // Closing frames at full rate on both sides.
  task automatic test_full_rate();
    wait_drained();
    idle_on = 1'b0;
    set_all(11'd5, 1'b1, 4'd9, 1'b1);
    send_frame(5, 1'b0);
    set_all(11'd6, 1'b0, 4'd7, 1'b0);
    send_frame(6, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_two[i] = '0;
      line_one[i] = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;
    row_cnt = 0;
    col_cnt = 0;
    size_reg = 11'(RST_IMAGE_SIZE);
    sharpen_reg = 1'b0;
    div_reg = RST_DIVISOR;
    drop_reg = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_kernel_corners();
    test_large_size();
    test_random_frames();
    test_full_rate();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** rgb_3x3_blur_sharpen_filter: PASSED **");
    end else begin
      $display("** rgb_3x3_blur_sharpen_filter: FAILED **");
    end
    $finish;
  end

endmodule
